// ----- design/stow_pkg.sv -----
// Shared types and codes for the counting semaphore table.
// Holds request and response beat layouts, status codes and controller states.
// No dependencies.
package stow_pkg;

  // Request kind
  typedef enum logic {
    OP_OPEN = 1'b0,
    OP_WAIT = 1'b1
  } op_e;

  // Response status codes
  typedef enum logic [2:0] {
    STAT_OPENED     = 3'd0,
    STAT_GRANTED    = 3'd1,
    STAT_BLOCKED    = 3'd2,
    STAT_UNKNOWN    = 3'd3,
    STAT_LISTENERS  = 3'd4,
    STAT_TABLE_FULL = 3'd5,
    STAT_WAIT_FULL  = 3'd6
  } status_e;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_MODIFY
  } ctrl_state_e;

  localparam int IdW  = 32;
  localparam int ValW = 32;
  localparam int PidW = 16;

  // Request beat
  typedef struct packed {
    op_e             op;
    logic [IdW-1:0]  sem_id;
    logic [ValW-1:0] initial_value;
    logic [PidW-1:0] pid;
  } req_t;

  // Response beat
  typedef struct packed {
    status_e        status;
    logic [IdW-1:0] echo_id;
  } resp_t;

endpackage

// ----- design/stow_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module stow_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds its data while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- design/stow_lookup.sv -----
// Key store and id match for the semaphore table: valid bits, keys, and
// lowest-slot selection for hit and free. Depends on stow_pkg.
module stow_lookup #(
  parameter int TABLE_SLOTS = 16,
  localparam int SlotW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [stow_pkg::IdW-1:0] key_i,
  output logic                     hit_o,
  output logic                     free_o,
  output logic [SlotW-1:0]         slot_o,
  input  logic                     alloc_i,
  input  logic [SlotW-1:0]         alloc_slot_i,
  input  logic [stow_pkg::IdW-1:0] alloc_key_i
);

  logic [TABLE_SLOTS-1:0]   valid_q;
  logic [stow_pkg::IdW-1:0] key_q [TABLE_SLOTS];
  logic [SlotW-1:0]         hit_slot;
  logic [SlotW-1:0]         free_slot;

  // Mark a slot live when an entry is created
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (alloc_i) begin
      valid_q[alloc_slot_i] <= 1'b1;
    end
  end

  // Store the key of a new entry
  always_ff @(posedge clk_i) begin
    if (alloc_i) begin
      key_q[alloc_slot_i] <= alloc_key_i;
    end
  end

  // Compare all keys; lowest matching and lowest free slot win
  always_comb begin
    hit_o     = 1'b0;
    free_o    = 1'b0;
    hit_slot  = '0;
    free_slot = '0;
    for (int s = TABLE_SLOTS - 1; s >= 0; s--) begin
      if (valid_q[s] && (key_q[s] == key_i)) begin
        hit_o    = 1'b1;
        hit_slot = SlotW'(s);
      end
      if (!valid_q[s]) begin
        free_o    = 1'b1;
        free_slot = SlotW'(s);
      end
    end
  end

  assign slot_o = hit_o ? hit_slot : free_slot;

endmodule

// ----- design/stow_ctrl.sv -----
// Request sequencer: takes a request beat, reads the entry, applies the open
// or wait rule, writes back and issues one response beat. Depends on stow_pkg.
module stow_ctrl #(
  parameter int TABLE_SLOTS = 16,
  parameter int MAX_WAITERS = 16,
  localparam int SlotW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1,
  localparam int CntW  = $clog2(MAX_WAITERS + 1),
  localparam int EntW  = stow_pkg::ValW + 2 * CntW,
  localparam int PidDepth = TABLE_SLOTS * MAX_WAITERS,
  localparam int PidAW = (PidDepth > 1) ? $clog2(PidDepth) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  stow_pkg::req_t            req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output stow_pkg::resp_t           resp_o,
  input  logic                      hit_i,
  input  logic                      free_i,
  input  logic [SlotW-1:0]          slot_i,
  output logic                      alloc_o,
  output logic [SlotW-1:0]          alloc_slot_o,
  output logic [stow_pkg::IdW-1:0]  alloc_key_o,
  output logic                      ent_re_o,
  output logic [SlotW-1:0]          ent_raddr_o,
  input  logic [EntW-1:0]           ent_rdata_i,
  output logic                      ent_we_o,
  output logic [SlotW-1:0]          ent_waddr_o,
  output logic [EntW-1:0]           ent_wdata_o,
  output logic                      pid_we_o,
  output logic [PidAW-1:0]          pid_waddr_o,
  output logic [stow_pkg::PidW-1:0] pid_wdata_o
);

  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_WAITERS);

  stow_pkg::ctrl_state_e state_q, state_d;
  stow_pkg::req_t        req_q;
  logic                  hit_q;
  logic                  free_q;
  logic [SlotW-1:0]      slot_q;
  logic                  out_valid_q, out_valid_d;
  stow_pkg::resp_t       resp_q, resp_d;

  logic                      accept;
  logic                      commit;
  logic [stow_pkg::ValW-1:0] cur_count;
  logic [CntW-1:0]           cur_lis;
  logic [CntW-1:0]           cur_wai;
  logic [stow_pkg::ValW-1:0] new_count;
  logic [CntW-1:0]           new_lis;
  logic [CntW-1:0]           new_wai;

  assign accept = in_valid_i && in_ready_o;
  assign commit = (state_q == stow_pkg::ST_MODIFY) && (!out_valid_q || out_ready_i);

  // Split the entry word read back from the RAM
  assign cur_count = ent_rdata_i[EntW-1 -: stow_pkg::ValW];
  assign cur_lis   = ent_rdata_i[2*CntW-1 -: CntW];
  assign cur_wai   = ent_rdata_i[CntW-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stow_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = stow_pkg::ST_MODIFY;
        end
      end
      stow_pkg::ST_MODIFY: begin
        if (commit) begin
          state_d = stow_pkg::ST_IDLE;
        end
      end
      default: state_d = stow_pkg::ST_IDLE;
    endcase
  end

  // Outputs: entry read, write-back, allocation and response
  always_comb begin
    in_ready_o   = (state_q == stow_pkg::ST_IDLE);
    ent_re_o     = accept;
    ent_raddr_o  = slot_i;
    ent_we_o     = 1'b0;
    ent_waddr_o  = slot_q;
    alloc_o      = 1'b0;
    alloc_slot_o = slot_q;
    alloc_key_o  = req_q.sem_id;
    pid_we_o     = 1'b0;
    pid_waddr_o  = PidAW'(slot_q) * PidAW'(MAX_WAITERS) + PidAW'(cur_wai);
    pid_wdata_o  = req_q.pid;
    new_count    = cur_count;
    new_lis      = cur_lis;
    new_wai      = cur_wai;
    out_valid_d  = out_valid_q && !out_ready_i;
    resp_d       = resp_q;
    if (commit) begin
      out_valid_d    = 1'b1;
      resp_d.echo_id = '0;
      if (req_q.op == stow_pkg::OP_OPEN) begin
        priority if (!hit_q && !free_q) begin
          resp_d.status = stow_pkg::STAT_TABLE_FULL;
        end else if (!hit_q) begin
          // Create the entry with one listener
          alloc_o        = 1'b1;
          ent_we_o       = 1'b1;
          new_count      = req_q.initial_value;
          new_lis        = CntW'(1);
          new_wai        = '0;
          resp_d.status  = stow_pkg::STAT_OPENED;
          resp_d.echo_id = req_q.sem_id;
        end else if (cur_lis >= MaxCnt) begin
          resp_d.status = stow_pkg::STAT_LISTENERS;
        end else begin
          ent_we_o       = 1'b1;
          new_lis        = cur_lis + CntW'(1);
          resp_d.status  = stow_pkg::STAT_OPENED;
          resp_d.echo_id = req_q.sem_id;
        end
      end else begin
        priority if (!hit_q) begin
          resp_d.status = stow_pkg::STAT_UNKNOWN;
        end else if (cur_count != '0) begin
          ent_we_o      = 1'b1;
          new_count     = cur_count - stow_pkg::ValW'(1);
          resp_d.status = stow_pkg::STAT_GRANTED;
        end else if (cur_wai >= MaxCnt) begin
          resp_d.status = stow_pkg::STAT_WAIT_FULL;
        end else begin
          // Append the caller to the blocked list
          ent_we_o      = 1'b1;
          pid_we_o      = 1'b1;
          new_wai       = cur_wai + CntW'(1);
          resp_d.status = stow_pkg::STAT_BLOCKED;
        end
      end
    end
    ent_wdata_o = {new_count, new_lis, new_wai};
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stow_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the request and its lookup result for the modify cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_i;
      hit_q  <= hit_i;
      free_q <= free_i;
      slot_q <= slot_i;
    end
    resp_q <= resp_d;
  end

  assign out_valid_o = out_valid_q;
  assign resp_o      = resp_q;

endmodule

// ----- design/semaphore_table_open_wait.sv -----
// Counting semaphore table, open and wait requests.
// Instantiates stow_lookup, stow_ctrl and two stow_ram memories; uses stow_pkg.
//
// Usage:
//   Request channel (in_valid_i / in_ready_o / req_i): one beat per request,
//   op selects open or wait on the 32-bit sem_id. Response channel
//   (out_valid_o / out_ready_i / resp_o): exactly one beat per request,
//   status code plus echo_id (the id on a successful open, else zero).
//   A request is looked up when accepted (key match plus entry RAM read);
//   the read-modify-write on the entry RAM then commits it and registers
//   its response. in_ready_o stays low from acceptance until that commit,
//   so no new request is taken until the current one has been committed.
//   The response sits in an output register; a stalled receiver holds the
//   block in its modify cycle only when a previous response is still
//   waiting, so one request can be in flight behind an untaken response.
//   Reset clears all valid bits, so the table starts empty; no clearing
//   pass is needed because every entry is fully written on creation.
module semaphore_table_open_wait #(
  parameter int TABLE_SLOTS = 16,
  parameter int MAX_WAITERS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  stow_pkg::req_t  req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output stow_pkg::resp_t resp_o
);

  localparam int SlotW    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CntW     = $clog2(MAX_WAITERS + 1);
  localparam int EntW     = stow_pkg::ValW + 2 * CntW;
  localparam int PidDepth = TABLE_SLOTS * MAX_WAITERS;
  localparam int PidAW    = (PidDepth > 1) ? $clog2(PidDepth) : 1;

  logic                      hit;
  logic                      free;
  logic [SlotW-1:0]          slot;
  logic                      alloc;
  logic [SlotW-1:0]          alloc_slot;
  logic [stow_pkg::IdW-1:0]  alloc_key;
  logic                      ent_re;
  logic [SlotW-1:0]          ent_raddr;
  logic [EntW-1:0]           ent_rdata;
  logic                      ent_we;
  logic [SlotW-1:0]          ent_waddr;
  logic [EntW-1:0]           ent_wdata;
  logic                      pid_we;
  logic [PidAW-1:0]          pid_waddr;
  logic [stow_pkg::PidW-1:0] pid_wdata;

  // Key match and slot allocation
  stow_lookup #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_lookup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (req_i.sem_id),
    .hit_o       (hit),
    .free_o      (free),
    .slot_o      (slot),
    .alloc_i     (alloc),
    .alloc_slot_i(alloc_slot),
    .alloc_key_i (alloc_key)
  );

  // Request sequencer
  stow_ctrl #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .MAX_WAITERS(MAX_WAITERS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_i       (req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .resp_o      (resp_o),
    .hit_i       (hit),
    .free_i      (free),
    .slot_i      (slot),
    .alloc_o     (alloc),
    .alloc_slot_o(alloc_slot),
    .alloc_key_o (alloc_key),
    .ent_re_o    (ent_re),
    .ent_raddr_o (ent_raddr),
    .ent_rdata_i (ent_rdata),
    .ent_we_o    (ent_we),
    .ent_waddr_o (ent_waddr),
    .ent_wdata_o (ent_wdata),
    .pid_we_o    (pid_we),
    .pid_waddr_o (pid_waddr),
    .pid_wdata_o (pid_wdata)
  );

  // Per-entry count, listener count and waiter count
  stow_ram #(
    .Width(EntW),
    .Depth(TABLE_SLOTS)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(ent_waddr),
    .wdata_i(ent_wdata),
    .re_i   (ent_re),
    .raddr_i(ent_raddr),
    .rdata_o(ent_rdata)
  );

  // Blocked-list process ids, one row of MAX_WAITERS per slot
  stow_ram #(
    .Width(stow_pkg::PidW),
    .Depth(PidDepth)
  ) u_pid_ram (
    .clk_i  (clk_i),
    .we_i   (pid_we),
    .waddr_i(pid_waddr),
    .wdata_i(pid_wdata),
    .re_i   (1'b0),
    .raddr_i('0),
    .rdata_o()
  );

endmodule
